// ===== src/mpas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpas_pkg
// Shared types and constants for the point-along-segment pipeline.
// ----------------------------------------------------------------------------
package mpas_pkg;

   localparam int MIN_LEN_W = 17;
   localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = 17'd1;

   typedef struct packed {
      logic valid;
      logic advance;
   } mpas_flow_type;

endpackage

// ===== src/move_point_along_segment.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_point_along_segment
// Moves a Q format point a signed distance along a segment, with optional
// projection onto the segment and a short-segment bypass.
// ----------------------------------------------------------------------------
// The block accepts one beat per cycle unless a result beat waits under
// rsp_stall, and returns one result beat for each, in order. Each beat passes
// through the chain of square-root cells (one root bit per cell), the chain of
// move divider cells (one quotient bit per cell) and the chain of projection
// divider cells. The whole pipeline holds while a result beat waits under
// rsp_stall, so req_stall follows rsp_stall in that case only.
// ----------------------------------------------------------------------------
module move_point_along_segment #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [mpas_pkg::MIN_LEN_W-1:0] csr_wr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [COORD_BITS-1:0] req_point_x,
   input  logic [COORD_BITS-1:0] req_point_y,
   input  logic [COORD_BITS-1:0] req_line_start_x,
   input  logic [COORD_BITS-1:0] req_line_start_y,
   input  logic [COORD_BITS-1:0] req_line_end_x,
   input  logic [COORD_BITS-1:0] req_line_end_y,
   input  logic [COORD_BITS-1:0] req_move_distance,
   input  logic                  req_clamp_to_ends,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COORD_BITS-1:0] rsp_new_x,
   output logic [COORD_BITS-1:0] rsp_new_y,
   output logic                  rsp_degenerate
);

   localparam int CW = COORD_BITS;
   localparam int FW = FRAC_BITS;
   localparam int DW = CW + 1;
   localparam int SW = 2 * DW;
   localparam int NW = 2 * CW + 1;
   localparam int PW = FW + DW;
   localparam int EW = CW + 3;

   localparam int SQ_SIDEW = 7 * CW + 1 + 2 * DW + SW;
   localparam int MX_SIDEW = 3 * CW + DW + 3;
   localparam int MY_SIDEW = 3 * CW + DW + 1 + SW;
   localparam int CL_SIDEW = 6 * CW + 2 * DW + 4;

   function automatic logic [DW-1:0] mag_dw(input logic [DW-1:0] v);
      return v[DW-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [CW-1:0] mag_cw(input logic [CW-1:0] v);
      return v[CW-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [CW-1:0] sat(input logic [EW-1:0] v);
      logic all_one;
      logic all_zero;
      all_one  = &v[EW-1:CW-1];
      all_zero = ~|v[EW-1:CW-1];
      if (all_one || all_zero) begin
         return v[CW-1:0];
      end else if (v[EW-1]) begin
         return {1'b1, {(CW-1){1'b0}}};
      end else begin
         return {1'b0, {(CW-1){1'b1}}};
      end
   endfunction

   logic                             advance;
   logic [mpas_pkg::MIN_LEN_W-1:0]   min_len_ff;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= mpas_pkg::MIN_LEN_RESET;
      end else if (csr_wr_en) begin
         min_len_ff <= csr_wr_data;
      end
   end

   // Stage 0: capture the beat and form the segment direction.
   logic          s0_valid_ff;
   logic [CW-1:0] s0_px_ff, s0_py_ff, s0_sx_ff, s0_sy_ff, s0_ex_ff, s0_ey_ff, s0_d_ff;
   logic          s0_clamp_ff;
   logic [DW-1:0] s0_dx_ff, s0_dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
      end
      if (advance) begin
         s0_px_ff    <= req_point_x;
         s0_py_ff    <= req_point_y;
         s0_sx_ff    <= req_line_start_x;
         s0_sy_ff    <= req_line_start_y;
         s0_ex_ff    <= req_line_end_x;
         s0_ey_ff    <= req_line_end_y;
         s0_d_ff     <= req_move_distance;
         s0_clamp_ff <= req_clamp_to_ends;
         s0_dx_ff    <= {req_line_end_x[CW-1], req_line_end_x}
                        - {req_line_start_x[CW-1], req_line_start_x};
         s0_dy_ff    <= {req_line_end_y[CW-1], req_line_end_y}
                        - {req_line_start_y[CW-1], req_line_start_y};
      end
   end

   // Stage 1: squares of the direction components.
   logic          s1_valid_ff;
   logic [CW-1:0] s1_px_ff, s1_py_ff, s1_sx_ff, s1_sy_ff, s1_ex_ff, s1_ey_ff, s1_d_ff;
   logic          s1_clamp_ff;
   logic [DW-1:0] s1_dx_ff, s1_dy_ff;
   logic [SW-1:0] s1_sqx_ff, s1_sqy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s0_valid_ff;
      end
      if (advance) begin
         s1_px_ff    <= s0_px_ff;
         s1_py_ff    <= s0_py_ff;
         s1_sx_ff    <= s0_sx_ff;
         s1_sy_ff    <= s0_sy_ff;
         s1_ex_ff    <= s0_ex_ff;
         s1_ey_ff    <= s0_ey_ff;
         s1_d_ff     <= s0_d_ff;
         s1_clamp_ff <= s0_clamp_ff;
         s1_dx_ff    <= s0_dx_ff;
         s1_dy_ff    <= s0_dy_ff;
         s1_sqx_ff   <= SW'(mag_dw(s0_dx_ff)) * SW'(mag_dw(s0_dx_ff));
         s1_sqy_ff   <= SW'(mag_dw(s0_dy_ff)) * SW'(mag_dw(s0_dy_ff));
      end
   end

   // Stage 2: squared length.
   logic                s2_valid_ff;
   logic [SW-1:0]       s2_s_ff;
   logic [SQ_SIDEW-1:0] s2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_s_ff    <= s1_sqx_ff + s1_sqy_ff;
         s2_side_ff <= {s1_px_ff, s1_py_ff, s1_sx_ff, s1_sy_ff, s1_ex_ff, s1_ey_ff,
                        s1_d_ff, s1_clamp_ff, s1_dx_ff, s1_dy_ff,
                        s1_sqx_ff + s1_sqy_ff};
      end
   end

   // Square-root chain: one root bit per cell.
   logic                sq_valid_w [0:DW];
   logic [DW+1:0]       sq_rem_w   [0:DW];
   logic [DW-1:0]       sq_root_w  [0:DW];
   logic [SW-1:0]       sq_bits_w  [0:DW];
   logic [SQ_SIDEW-1:0] sq_side_w  [0:DW];

   assign sq_valid_w[0] = s2_valid_ff;
   assign sq_rem_w[0]   = '0;
   assign sq_root_w[0]  = '0;
   assign sq_bits_w[0]  = s2_s_ff;
   assign sq_side_w[0]  = s2_side_ff;

   for (genvar i = 0; i < DW; i++) begin : g_sqrt
      mpas_pkg::mpas_flow_type flow;
      assign flow.valid   = sq_valid_w[i];
      assign flow.advance = advance;
      mpas_sqrt_cell #(
         .RW    (DW),
         .SIDEW (SQ_SIDEW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .flow      (flow),
         .in_rem    (sq_rem_w[i]),
         .in_root   (sq_root_w[i]),
         .in_bits   (sq_bits_w[i]),
         .in_side   (sq_side_w[i]),
         .out_valid (sq_valid_w[i+1]),
         .out_rem   (sq_rem_w[i+1]),
         .out_root  (sq_root_w[i+1]),
         .out_bits  (sq_bits_w[i+1]),
         .out_side  (sq_side_w[i+1])
      );
   end

   logic [CW-1:0] q_px, q_py, q_sx, q_sy, q_ex, q_ey, q_d;
   logic          q_clamp;
   logic [DW-1:0] q_dx, q_dy, q_len;
   logic [SW-1:0] q_s;

   assign {q_px, q_py, q_sx, q_sy, q_ex, q_ey, q_d, q_clamp, q_dx, q_dy, q_s} =
      sq_side_w[DW];
   assign q_len = sq_root_w[DW];

   // Stage 3: short-segment test and move products.
   logic                s3_valid_ff;
   logic [NW-1:0]       s3_prodx_ff, s3_prody_ff;
   logic [DW-1:0]       s3_len_ff;
   logic [MX_SIDEW-1:0] s3_sidex_ff;
   logic [MY_SIDEW-1:0] s3_sidey_ff;
   logic                q_degen;

   assign q_degen = (q_len == '0) || (q_len < DW'(min_len_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= sq_valid_w[DW];
      end
      if (advance) begin
         s3_prodx_ff <= NW'(mag_dw(q_dx)) * NW'(mag_cw(q_d));
         s3_prody_ff <= NW'(mag_dw(q_dy)) * NW'(mag_cw(q_d));
         s3_len_ff   <= q_len;
         s3_sidex_ff <= {q_px, q_sx, q_ex, q_dx, q_dx[DW-1] ^ q_d[CW-1], q_clamp, q_degen};
         s3_sidey_ff <= {q_py, q_sy, q_ey, q_dy, q_dy[DW-1] ^ q_d[CW-1], q_s};
      end
   end

   // Move divider chains: offset = product / length, one quotient bit per cell.
   logic                mx_valid_w [0:CW];
   logic [DW-1:0]       mx_rem_w   [0:CW];
   logic [CW-1:0]       mx_nq_w    [0:CW];
   logic [DW-1:0]       mx_den_w   [0:CW];
   logic [MX_SIDEW-1:0] mx_side_w  [0:CW];
   logic                my_valid_w [0:CW];
   logic [DW-1:0]       my_rem_w   [0:CW];
   logic [CW-1:0]       my_nq_w    [0:CW];
   logic [DW-1:0]       my_den_w   [0:CW];
   logic [MY_SIDEW-1:0] my_side_w  [0:CW];

   assign mx_valid_w[0] = s3_valid_ff;
   assign mx_rem_w[0]   = s3_prodx_ff[NW-1:CW];
   assign mx_nq_w[0]    = s3_prodx_ff[CW-1:0];
   assign mx_den_w[0]   = s3_len_ff;
   assign mx_side_w[0]  = s3_sidex_ff;
   assign my_valid_w[0] = s3_valid_ff;
   assign my_rem_w[0]   = s3_prody_ff[NW-1:CW];
   assign my_nq_w[0]    = s3_prody_ff[CW-1:0];
   assign my_den_w[0]   = s3_len_ff;
   assign my_side_w[0]  = s3_sidey_ff;

   for (genvar i = 0; i < CW; i++) begin : g_move
      mpas_pkg::mpas_flow_type flow_x;
      mpas_pkg::mpas_flow_type flow_y;
      assign flow_x.valid   = mx_valid_w[i];
      assign flow_x.advance = advance;
      assign flow_y.valid   = my_valid_w[i];
      assign flow_y.advance = advance;
      mpas_div_cell #(
         .RW    (DW),
         .DENW  (DW),
         .QW    (CW),
         .SIDEW (MX_SIDEW)
      ) u_cell_x (
         .clock     (clock),
         .reset     (reset),
         .flow      (flow_x),
         .in_rem    (mx_rem_w[i]),
         .in_nq     (mx_nq_w[i]),
         .in_den    (mx_den_w[i]),
         .in_side   (mx_side_w[i]),
         .out_valid (mx_valid_w[i+1]),
         .out_rem   (mx_rem_w[i+1]),
         .out_nq    (mx_nq_w[i+1]),
         .out_den   (mx_den_w[i+1]),
         .out_side  (mx_side_w[i+1])
      );
      mpas_div_cell #(
         .RW    (DW),
         .DENW  (DW),
         .QW    (CW),
         .SIDEW (MY_SIDEW)
      ) u_cell_y (
         .clock     (clock),
         .reset     (reset),
         .flow      (flow_y),
         .in_rem    (my_rem_w[i]),
         .in_nq     (my_nq_w[i]),
         .in_den    (my_den_w[i]),
         .in_side   (my_side_w[i]),
         .out_valid (my_valid_w[i+1]),
         .out_rem   (my_rem_w[i+1]),
         .out_nq    (my_nq_w[i+1]),
         .out_den   (my_den_w[i+1]),
         .out_side  (my_side_w[i+1])
      );
   end

   logic [CW-1:0] m_px, m_sx, m_ex, m_py, m_sy, m_ey;
   logic [DW-1:0] m_dx, m_dy, m_len;
   logic          m_negx, m_negy, m_clamp, m_degen;
   logic [SW-1:0] m_s;
   logic [DW-1:0] m_restx, m_resty;
   logic [CW:0]   m_magx, m_magy;
   logic [EW-1:0] m_sumx, m_sumy;

   assign {m_px, m_sx, m_ex, m_dx, m_negx, m_clamp, m_degen} = mx_side_w[CW];
   assign {m_py, m_sy, m_ey, m_dy, m_negy, m_s} = my_side_w[CW];
   assign m_len   = mx_den_w[CW];
   assign m_restx = m_len - mx_rem_w[CW];
   assign m_resty = m_len - my_rem_w[CW];
   assign m_magx  = (CW+1)'(mx_nq_w[CW]) + (CW+1)'(mx_rem_w[CW] >= m_restx);
   assign m_magy  = (CW+1)'(my_nq_w[CW]) + (CW+1)'(my_rem_w[CW] >= m_resty);
   assign m_sumx  = m_negx ? ({{3{m_px[CW-1]}}, m_px} - EW'(m_magx))
                           : ({{3{m_px[CW-1]}}, m_px} + EW'(m_magx));
   assign m_sumy  = m_negy ? ({{3{m_py[CW-1]}}, m_py} - EW'(m_magy))
                           : ({{3{m_py[CW-1]}}, m_py} + EW'(m_magy));

   // Stage 4: moved point, saturated; the short segment keeps the point.
   logic          s4_valid_ff;
   logic [CW-1:0] s4_rx_ff, s4_ry_ff, s4_sx_ff, s4_sy_ff, s4_ex_ff, s4_ey_ff;
   logic [DW-1:0] s4_dx_ff, s4_dy_ff;
   logic [SW-1:0] s4_s_ff;
   logic          s4_clamp_ff, s4_degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= mx_valid_w[CW];
      end
      if (advance) begin
         s4_rx_ff    <= m_degen ? m_px : sat(m_sumx);
         s4_ry_ff    <= m_degen ? m_py : sat(m_sumy);
         s4_sx_ff    <= m_sx;
         s4_sy_ff    <= m_sy;
         s4_ex_ff    <= m_ex;
         s4_ey_ff    <= m_ey;
         s4_dx_ff    <= m_dx;
         s4_dy_ff    <= m_dy;
         s4_s_ff     <= m_s;
         s4_clamp_ff <= m_clamp;
         s4_degen_ff <= m_degen;
      end
   end

   // Stage 5: projection products.
   logic [DW-1:0] s4_relx, s4_rely;
   logic          s5_valid_ff;
   logic [SW-1:0] s5_ax_ff, s5_ay_ff;
   logic [CW-1:0] s5_rx_ff, s5_ry_ff, s5_sx_ff, s5_sy_ff, s5_ex_ff, s5_ey_ff;
   logic [DW-1:0] s5_dx_ff, s5_dy_ff;
   logic [SW-1:0] s5_s_ff;
   logic          s5_clamp_ff, s5_degen_ff;

   assign s4_relx = {s4_rx_ff[CW-1], s4_rx_ff} - {s4_sx_ff[CW-1], s4_sx_ff};
   assign s4_rely = {s4_ry_ff[CW-1], s4_ry_ff} - {s4_sy_ff[CW-1], s4_sy_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid_ff;
      end
      if (advance) begin
         s5_ax_ff    <= SW'($signed(s4_relx) * $signed(s4_dx_ff));
         s5_ay_ff    <= SW'($signed(s4_rely) * $signed(s4_dy_ff));
         s5_rx_ff    <= s4_rx_ff;
         s5_ry_ff    <= s4_ry_ff;
         s5_sx_ff    <= s4_sx_ff;
         s5_sy_ff    <= s4_sy_ff;
         s5_ex_ff    <= s4_ex_ff;
         s5_ey_ff    <= s4_ey_ff;
         s5_dx_ff    <= s4_dx_ff;
         s5_dy_ff    <= s4_dy_ff;
         s5_s_ff     <= s4_s_ff;
         s5_clamp_ff <= s4_clamp_ff;
         s5_degen_ff <= s4_degen_ff;
      end
   end

   // Stage 6: projection numerator and its range against the squared length.
   logic [SW:0]         s5_num;
   logic                s5_le0, s5_ges;
   logic                s6_valid_ff;
   logic [SW-1:0]       s6_num_ff;
   logic [SW-1:0]       s6_s_ff;
   logic [CL_SIDEW-1:0] s6_side_ff;

   assign s5_num = {s5_ax_ff[SW-1], s5_ax_ff} + {s5_ay_ff[SW-1], s5_ay_ff};
   assign s5_le0 = s5_num[SW] || (s5_num == '0);
   assign s5_ges = !s5_num[SW] && (s5_num[SW-1:0] >= s5_s_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (advance) begin
         s6_valid_ff <= s5_valid_ff;
      end
      if (advance) begin
         s6_num_ff  <= s5_num[SW-1:0];
         s6_s_ff    <= s5_s_ff;
         s6_side_ff <= {s5_sx_ff, s5_sy_ff, s5_ex_ff, s5_ey_ff, s5_rx_ff, s5_ry_ff,
                        s5_dx_ff, s5_dy_ff, s5_clamp_ff, s5_degen_ff, s5_le0, s5_ges};
      end
   end

   // Projection divider chain: t = num * 2^FRAC_BITS / S.
   logic                cl_valid_w [0:FW];
   logic [SW-1:0]       cl_rem_w   [0:FW];
   logic [FW-1:0]       cl_nq_w    [0:FW];
   logic [SW-1:0]       cl_den_w   [0:FW];
   logic [CL_SIDEW-1:0] cl_side_w  [0:FW];

   assign cl_valid_w[0] = s6_valid_ff;
   assign cl_rem_w[0]   = s6_num_ff;
   assign cl_nq_w[0]    = '0;
   assign cl_den_w[0]   = s6_s_ff;
   assign cl_side_w[0]  = s6_side_ff;

   for (genvar i = 0; i < FW; i++) begin : g_proj
      mpas_pkg::mpas_flow_type flow;
      assign flow.valid   = cl_valid_w[i];
      assign flow.advance = advance;
      mpas_div_cell #(
         .RW    (SW),
         .DENW  (SW),
         .QW    (FW),
         .SIDEW (CL_SIDEW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .flow      (flow),
         .in_rem    (cl_rem_w[i]),
         .in_nq     (cl_nq_w[i]),
         .in_den    (cl_den_w[i]),
         .in_side   (cl_side_w[i]),
         .out_valid (cl_valid_w[i+1]),
         .out_rem   (cl_rem_w[i+1]),
         .out_nq    (cl_nq_w[i+1]),
         .out_den   (cl_den_w[i+1]),
         .out_side  (cl_side_w[i+1])
      );
   end

   logic [CW-1:0] c_sx, c_sy, c_ex, c_ey, c_rx, c_ry;
   logic [DW-1:0] c_dx, c_dy;
   logic          c_clamp, c_degen, c_le0, c_ges;

   assign {c_sx, c_sy, c_ex, c_ey, c_rx, c_ry, c_dx, c_dy, c_clamp, c_degen, c_le0, c_ges} =
      cl_side_w[FW];

   // Stage 7: step along the direction by the fraction t.
   logic          s7_valid_ff;
   logic [PW-1:0] s7_px_ff, s7_py_ff;
   logic [CW-1:0] s7_sx_ff, s7_sy_ff, s7_ex_ff, s7_ey_ff, s7_rx_ff, s7_ry_ff;
   logic          s7_negx_ff, s7_negy_ff;
   logic          s7_clamp_ff, s7_degen_ff, s7_le0_ff, s7_ges_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else if (advance) begin
         s7_valid_ff <= cl_valid_w[FW];
      end
      if (advance) begin
         s7_px_ff    <= PW'(cl_nq_w[FW]) * PW'(mag_dw(c_dx));
         s7_py_ff    <= PW'(cl_nq_w[FW]) * PW'(mag_dw(c_dy));
         s7_sx_ff    <= c_sx;
         s7_sy_ff    <= c_sy;
         s7_ex_ff    <= c_ex;
         s7_ey_ff    <= c_ey;
         s7_rx_ff    <= c_rx;
         s7_ry_ff    <= c_ry;
         s7_negx_ff  <= c_dx[DW-1];
         s7_negy_ff  <= c_dy[DW-1];
         s7_clamp_ff <= c_clamp;
         s7_degen_ff <= c_degen;
         s7_le0_ff   <= c_le0;
         s7_ges_ff   <= c_ges;
      end
   end

   logic [PW:0]   f_rndx, f_rndy;
   logic [EW-1:0] f_sumx, f_sumy;
   logic [CW-1:0] f_x, f_y;

   assign f_rndx = (PW+1)'(s7_px_ff) + (PW+1)'({1'b1, {(FW-1){1'b0}}});
   assign f_rndy = (PW+1)'(s7_py_ff) + (PW+1)'({1'b1, {(FW-1){1'b0}}});
   assign f_sumx = s7_negx_ff ? ({{3{s7_sx_ff[CW-1]}}, s7_sx_ff} - EW'(f_rndx[PW:FW]))
                              : ({{3{s7_sx_ff[CW-1]}}, s7_sx_ff} + EW'(f_rndx[PW:FW]));
   assign f_sumy = s7_negy_ff ? ({{3{s7_sy_ff[CW-1]}}, s7_sy_ff} - EW'(f_rndy[PW:FW]))
                              : ({{3{s7_sy_ff[CW-1]}}, s7_sy_ff} + EW'(f_rndy[PW:FW]));

   always_comb begin
      if (s7_degen_ff || !s7_clamp_ff) begin
         f_x = s7_rx_ff;
         f_y = s7_ry_ff;
      end else if (s7_le0_ff) begin
         f_x = s7_sx_ff;
         f_y = s7_sy_ff;
      end else if (s7_ges_ff) begin
         f_x = s7_ex_ff;
         f_y = s7_ey_ff;
      end else begin
         f_x = sat(f_sumx);
         f_y = sat(f_sumy);
      end
   end

   // Output register: holds the result beat while rsp_stall is high.
   logic          rsp_valid_ff;
   logic [CW-1:0] rsp_x_ff, rsp_y_ff;
   logic          rsp_degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s7_valid_ff;
      end
      if (advance) begin
         rsp_x_ff     <= f_x;
         rsp_y_ff     <= f_y;
         rsp_degen_ff <= s7_degen_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_new_x      = rsp_x_ff;
   assign rsp_new_y      = rsp_y_ff;
   assign rsp_degenerate = rsp_degen_ff;

   // Checks on the arithmetic chains.
   logic [SW+1:0] chk_lo, chk_hi;

   assign chk_lo = (SW+2)'(q_len) * (SW+2)'(q_len);
   assign chk_hi = ((SW+2)'(q_len) + 1'b1) * ((SW+2)'(q_len) + 1'b1);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result beat valid right after reset.");

   a_sqrt_floor: assert property (@(posedge clock) disable iff (reset)
      sq_valid_w[DW] |-> (chk_lo <= (SW+2)'(q_s)) && (chk_hi > (SW+2)'(q_s)))
      else $error("Square root chain result is not the floor root.");

   a_move_rem: assert property (@(posedge clock) disable iff (reset)
      (mx_valid_w[CW] && !m_degen) |-> (mx_rem_w[CW] < m_len) && (my_rem_w[CW] < m_len))
      else $error("Move divider remainder not below the length.");

   a_proj_rem: assert property (@(posedge clock) disable iff (reset)
      (cl_valid_w[FW] && !c_le0 && !c_ges) |-> (cl_rem_w[FW] < cl_den_w[FW]))
      else $error("Projection divider remainder not below the squared length.");

endmodule

// ===== src/mpas_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpas_sqrt_cell
// One digit step of a restoring integer square root: takes two radicand bits
// and settles one root bit, then registers the partial result and the beat.
// ----------------------------------------------------------------------------
module mpas_sqrt_cell #(
   parameter int RW    = 33,
   parameter int SIDEW = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mpas_pkg::mpas_flow_type flow,
   input  logic [RW+1:0]         in_rem,
   input  logic [RW-1:0]         in_root,
   input  logic [2*RW-1:0]       in_bits,
   input  logic [SIDEW-1:0]      in_side,
   output logic                  out_valid,
   output logic [RW+1:0]         out_rem,
   output logic [RW-1:0]         out_root,
   output logic [2*RW-1:0]       out_bits,
   output logic [SIDEW-1:0]      out_side
);

   logic [RW+3:0]   r4;
   logic [RW+3:0]   trial;
   logic [RW+3:0]   diff;
   logic            ge;
   logic [RW+1:0]   rem_in;
   logic [RW-1:0]   root_in;
   logic [2*RW-1:0] bits_in;

   logic            valid_ff;
   logic [RW+1:0]   rem_ff;
   logic [RW-1:0]   root_ff;
   logic [2*RW-1:0] bits_ff;
   logic [SIDEW-1:0] side_ff;

   always_comb begin
      r4      = {in_rem, in_bits[2*RW-1 -: 2]};
      trial   = (RW+4)'({in_root, 2'b01});
      ge      = (r4 >= trial);
      diff    = r4 - trial;
      rem_in  = ge ? diff[RW+1:0] : r4[RW+1:0];
      root_in = {in_root[RW-2:0], ge};
      bits_in = {in_bits[2*RW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (flow.advance) begin
         valid_ff <= flow.valid;
      end
      if (flow.advance) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         bits_ff <= bits_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_bits  = bits_ff;
   assign out_side  = side_ff;

endmodule

// ===== src/mpas_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpas_div_cell
// One step of a restoring divider: shifts in one dividend bit, settles one
// quotient bit, then registers the partial result and the beat.
// ----------------------------------------------------------------------------
module mpas_div_cell #(
   parameter int RW    = 33,
   parameter int DENW  = 33,
   parameter int QW    = 32,
   parameter int SIDEW = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mpas_pkg::mpas_flow_type flow,
   input  logic [RW-1:0]         in_rem,
   input  logic [QW-1:0]         in_nq,
   input  logic [DENW-1:0]       in_den,
   input  logic [SIDEW-1:0]      in_side,
   output logic                  out_valid,
   output logic [RW-1:0]         out_rem,
   output logic [QW-1:0]         out_nq,
   output logic [DENW-1:0]       out_den,
   output logic [SIDEW-1:0]      out_side
);

   logic [RW:0]      rem2;
   logic [RW:0]      dext;
   logic [RW:0]      diff;
   logic             ge;
   logic [RW-1:0]    rem_in;
   logic [QW-1:0]    nq_in;

   logic             valid_ff;
   logic [RW-1:0]    rem_ff;
   logic [QW-1:0]    nq_ff;
   logic [DENW-1:0]  den_ff;
   logic [SIDEW-1:0] side_ff;

   always_comb begin
      rem2   = {in_rem, in_nq[QW-1]};
      dext   = (RW+1)'(in_den);
      ge     = (rem2 >= dext);
      diff   = rem2 - dext;
      rem_in = ge ? diff[RW-1:0] : rem2[RW-1:0];
      nq_in  = {in_nq[QW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (flow.advance) begin
         valid_ff <= flow.valid;
      end
      if (flow.advance) begin
         rem_ff  <= rem_in;
         nq_ff   <= nq_in;
         den_ff  <= in_den;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_nq    = nq_ff;
   assign out_den   = den_ff;
   assign out_side  = side_ff;

endmodule
